// File: design/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types, widths and helpers for the maximal square of ones block.
// ----------------------------------------------------------------------------
package msq_pkg;

  // widest image row the line buffer holds
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int SIDE_W    = COL_W + 1;
  localparam int AREA_W    = 2 * SIDE_W - 1;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [SIDE_W-1:0] side_t;
  typedef logic [AREA_W-1:0] area_t;

  // pixel as issued to the compute stage
  typedef struct packed {
    col_t col;
    logic first_row;
    logic pixel_is_one;
    logic end_of_frame;
  } issue_t;

  // finished frame result
  typedef struct packed {
    logic  valid;
    side_t side;
  } result_t;

  // zero width reads as one, oversize width saturates
  function automatic side_t width_in_use(side_t row_width);
    side_t w;
    if (row_width == '0) begin
      w = side_t'(1);
    end else if (row_width > side_t'(MAX_WIDTH)) begin
      w = side_t'(MAX_WIDTH);
    end else begin
      w = row_width;
    end
    return w;
  endfunction

endpackage

// File: design/msq_line_buf.sv
// ----------------------------------------------------------------------------
// msq_line_buf
// Line buffer holding the previous row's square sides, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
module msq_line_buf
  import msq_pkg::*;
(
  input  logic  clk,
  input  logic  rd_en,
  input  col_t  rd_addr,
  output side_t rd_data,
  input  logic  wr_en,
  input  col_t  wr_addr,
  input  side_t wr_data
);

  side_t mem [MAX_WIDTH];
  side_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/msq_scan_ctrl.sv
// ----------------------------------------------------------------------------
// msq_scan_ctrl
// Raster position tracking: column index and first-row flag per pixel.
// ----------------------------------------------------------------------------
module msq_scan_ctrl
  import msq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  side_t  row_width,
  input  logic   accept,
  input  logic   pixel_is_one,
  input  logic   end_of_frame,
  output issue_t iss
);

  col_t  col_r, col_nxt;
  logic  first_r, first_nxt;
  side_t w;
  col_t  cur_col;
  logic  cur_first;
  side_t col_inc;

  assign w = width_in_use(row_width);

  // position of the pixel being accepted
  always_comb begin
    if (side_t'(col_r) >= w) begin
      cur_col   = '0;
      cur_first = 1'b0;
    end else begin
      cur_col   = col_r;
      cur_first = first_r;
    end
  end

  // position of the following pixel
  assign col_inc = side_t'(cur_col) + side_t'(1);

  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    if (accept) begin
      if (end_of_frame) begin
        col_nxt   = '0;
        first_nxt = 1'b1;
      end else if (col_inc >= w) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = col_inc[COL_W-1:0];
        first_nxt = cur_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

  assign iss.col          = cur_col;
  assign iss.first_row    = cur_first;
  assign iss.pixel_is_one = pixel_is_one;
  assign iss.end_of_frame = end_of_frame;

endmodule

// File: design/msq_side_calc.sv
// ----------------------------------------------------------------------------
// msq_side_calc
// Compute stage: square side from up, left and up-left neighbors, line
// buffer write-back with forwarding, running largest side per frame.
// ----------------------------------------------------------------------------
module msq_side_calc
  import msq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  issue_t  iss,
  input  side_t   rd_data,
  input  logic    out_busy,
  output logic    hold,
  output logic    wr_en,
  output col_t    wr_addr,
  output side_t   wr_data,
  output result_t res
);

  logic   s1_valid_r, s1_valid_nxt;
  issue_t s1_r;
  logic   fwd_hit_r;
  side_t  fwd_data_r;
  side_t  left_r;
  side_t  ul_r;
  side_t  best_r, best_nxt;
  logic   fire;
  side_t  up;
  side_t  min_ab;
  side_t  min3;
  side_t  side;
  side_t  best_new;

  // a frame-end pixel waits while the result register is still occupied
  assign hold = s1_valid_r && s1_r.end_of_frame && out_busy;
  assign fire = s1_valid_r && !hold;

  // up neighbor, bypassing a write that raced the read
  assign up = fwd_hit_r ? fwd_data_r : rd_data;

  // side of the largest square ending at this pixel
  assign min_ab = (up < left_r) ? up : left_r;
  assign min3   = (min_ab < ul_r) ? min_ab : ul_r;

  always_comb begin
    if (!s1_r.pixel_is_one) begin
      side = '0;
    end else if (s1_r.first_row || s1_r.col == '0) begin
      side = side_t'(1);
    end else begin
      side = min3 + side_t'(1);
    end
  end

  assign best_new = (side > best_r) ? side : best_r;

  always_comb begin
    best_nxt = best_r;
    if (fire) begin
      best_nxt = s1_r.end_of_frame ? '0 : best_new;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      best_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      best_r     <= best_nxt;
    end
  end

  // stage payload and forwarding capture
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r       <= iss;
      fwd_hit_r  <= fire && (s1_r.col == iss.col);
      fwd_data_r <= side;
    end
  end

  // neighbors for the next pixel
  always_ff @(posedge clk) begin
    if (fire) begin
      left_r <= side;
      ul_r   <= up;
    end
  end

  assign wr_en     = fire;
  assign wr_addr   = s1_r.col;
  assign wr_data   = side;
  assign res.valid = fire && s1_r.end_of_frame;
  assign res.side  = best_new;

endmodule

// File: design/maximal_square_of_ones.sv
// ----------------------------------------------------------------------------
// maximal_square_of_ones
// Largest all-ones square over a raster-order binary image stream.
// ----------------------------------------------------------------------------
// Path: compute stage register, then result register. Throughput: one pixel
//   per cycle while in_stall is low; line buffer read at accept, written back
//   from the compute stage, with a bypass for same-column back-to-back.
// Reset: synchronous active-low rst_n clears position, frame best and valid
//   flags; row_width resets to 1024. Line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module maximal_square_of_ones
  import msq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_pixel_is_one,
  input  logic              in_end_of_frame,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIDE_W-1:0] out_largest_side,
  output logic [AREA_W-1:0] out_largest_area,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] cfg_row_width
);

  side_t   row_width_r;
  logic    accept;
  logic    hold;
  issue_t  iss;
  side_t   rd_data;
  logic    wr_en;
  col_t    wr_addr;
  side_t   wr_data;
  result_t res;
  logic    out_valid_r, out_valid_nxt;
  side_t   out_side_r;
  logic    out_busy;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= side_t'(MAX_WIDTH);
    end else if (cfg_valid && cfg_ready) begin
      row_width_r <= cfg_row_width;
    end
  end

  // input transaction
  assign in_stall = hold;
  assign accept   = in_valid && !in_stall;

  msq_scan_ctrl u_scan_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .row_width    (row_width_r),
    .accept       (accept),
    .pixel_is_one (in_pixel_is_one),
    .end_of_frame (in_end_of_frame),
    .iss          (iss)
  );

  msq_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (iss.col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_busy = out_valid_r && out_stall;

  msq_side_calc u_side_calc (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .iss      (iss),
    .rd_data  (rd_data),
    .out_busy (out_busy),
    .hold     (hold),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res      (res)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_side_r <= res.side;
    end
  end

  // area at full width so the square is not cut to the side width
  assign out_valid        = out_valid_r;
  assign out_largest_side = out_side_r;
  assign out_largest_area = AREA_W'(out_side_r) * AREA_W'(out_side_r);

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for maximal_square_of_ones: streams binary frames in
// raster order under varied flow control and row widths, and checks every
// frame's largest square side and area against a behavioral model of the
// square-side recurrence kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb;
  import msq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_SETTLE  = 4;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES  = 300;
  localparam int WIDTH_ALL_ONES = (1 << SIDE_W) - 1;

  typedef struct {
    side_t side;
    area_t area;
  } frame_result_t;

  // kinds of pixel content for a random frame
  typedef enum int {DENSE, PATCHY, EVEN, SPARSE, SOLID_BLOCK} fill_t;

  // model of the square-side recurrence plus the frame results still due
  class square_tracker;
    side_t row_width;
    side_t line_sides [MAX_WIDTH];
    side_t left_side;
    side_t upper_left_side;
    side_t best_side;
    int col_pos;
    bit first_row;
    int written_cols;
    int errors;
    int frames_seen;
    frame_result_t results_due [$];

    function new();
      row_width = side_t'(MAX_WIDTH);
      foreach (line_sides[i]) line_sides[i] = '0;
      written_cols = 0;
      errors = 0;
      frames_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      left_side = '0;
      upper_left_side = '0;
      best_side = '0;
      col_pos = 0;
      first_row = 1'b1;
    endfunction

    // zero reads as one column, oversize saturates at the buffer depth
    function int active_width();
      if (row_width == '0) return 1;
      if (int'(row_width) > MAX_WIDTH) return MAX_WIDTH;
      return int'(row_width);
    endfunction

    // advance the model by one accepted pixel transaction
    function void take_pixel(bit pix, bit last);
      int w;
      side_t above;
      side_t least;
      side_t side;
      frame_result_t r;
      w = active_width();
      // a width drop can leave the column past the row end
      if (col_pos >= w) begin
        col_pos = 0;
        first_row = 1'b0;
      end
      above = line_sides[col_pos];
      if (!pix) begin
        side = '0;
      end else if (first_row || col_pos == 0) begin
        side = side_t'(1);
      end else begin
        least = above;
        if (left_side < least) least = left_side;
        if (upper_left_side < least) least = upper_left_side;
        side = least + side_t'(1);
      end
      if (side > best_side) best_side = side;
      upper_left_side = above;
      line_sides[col_pos] = side;
      left_side = side;
      if (col_pos + 1 > written_cols) written_cols = col_pos + 1;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        first_row = 1'b0;
      end
      if (last) begin
        r.side = best_side;
        r.area = area_t'(int'(best_side) * int'(best_side));
        results_due.push_back(r);
        clear_frame();
      end
    endfunction

    // compare one result transaction with the oldest frame due
    function void match_frame_result(side_t side, area_t area);
      frame_result_t r;
      if (results_due.size() == 0) begin
        errors++;
        $error("result with no frame pending: side %0d area %0d", side, area);
        return;
      end
      r = results_due.pop_front();
      frames_seen++;
      if (side !== r.side) begin
        errors++;
        $error("largest_side: expected %0d, got %0d", r.side, side);
      end
      if (area !== r.area) begin
        errors++;
        $error("largest_area: expected %0d, got %0d", r.area, area);
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_pixel_is_one = 1'b0;
  logic  in_end_of_frame = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  side_t out_largest_side;
  area_t out_largest_area;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  side_t cfg_row_width = '0;

  square_tracker tracker = new();
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int stall_hold = 0;
  int cycle_count = 0;
  int pixels_sent = 0;
  int width_writes = 0;
  int idle_plan [4] = '{0, 88, 0, 38};
  int stall_plan [4] = '{0, 0, 88, 38};

  maximal_square_of_ones uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_is_one  (in_pixel_is_one),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_largest_side (out_largest_side),
    .out_largest_area (out_largest_area),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_row_width    (cfg_row_width)
  );

  always #5 clk = ~clk;

  // result side: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // check each accepted result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.match_frame_result(out_largest_side, out_largest_area);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // offer one pixel, with random idle cycles ahead of it
  task automatic send_pixel(bit pix, bit last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_is_one <= pix;
    in_end_of_frame <= last;
    do @(posedge clk); while (in_stall);
    tracker.take_pixel(pix, last);
    pixels_sent++;
  endtask

  // write row_width once the block has drained
  task automatic write_width(side_t w);
    in_valid <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_row_width <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.row_width = w;
    width_writes++;
  endtask

  // mostly narrow rows, with zero, oversize and wider ones mixed in
  function automatic side_t pick_width();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5) return '0;
    if (roll < 10) return side_t'($urandom_range(WIDTH_ALL_ONES, MAX_WIDTH));
    if (roll < 18) return side_t'($urandom_range(200, 33));
    return side_t'($urandom_range(24, 1));
  endfunction

  task automatic send_random_frame();
    int w;
    int len;
    int r0;
    int c0;
    int k;
    int cut_at;
    int r;
    int c;
    int lim;
    fill_t fill;
    bit pix;
    if ($urandom_range(99) < 60) write_width(pick_width());
    w = tracker.active_width();
    if (w <= 32) begin
      len = w * $urandom_range(6, 1);
      // some frames stop part way through a row
      if ($urandom_range(99) < 30) len = $urandom_range(len, 1);
    end else begin
      len = $urandom_range(96, 1);
    end
    fill = fill_t'($urandom_range(SOLID_BLOCK, DENSE));
    k = $urandom_range(8, 1);
    r0 = $urandom_range(3);
    c0 = $urandom_range(w > 16 ? 15 : w - 1);
    cut_at = -1;
    if (len > 1 && $urandom_range(99) < 10) cut_at = $urandom_range(len - 1, 1);
    for (int i = 0; i < len; i++) begin
      // width change mid-frame, only onto line buffer entries already written
      if (i == cut_at) begin
        lim = tracker.written_cols < 64 ? tracker.written_cols : 64;
        write_width(side_t'($urandom_range(lim, 1)));
      end
      r = i / w;
      c = i % w;
      case (fill)
        DENSE:   pix = $urandom_range(99) < 95;
        PATCHY:  pix = $urandom_range(99) < 70;
        EVEN:    pix = $urandom_range(1);
        SPARSE:  pix = $urandom_range(99) < 10;
        default: pix = (r >= r0 && r < r0 + k && c >= c0 && c < c0 + k) ||
                       ($urandom_range(99) < 3);
      endcase
      send_pixel(pix, i == len - 1);
    end
  endtask

  initial begin
    int phase_end;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset width, single-pixel frames
    send_pixel(1'b1, 1'b1);
    send_pixel(1'b0, 1'b1);
    // zero width behaves as one column
    write_width('0);
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    // oversize width saturates
    write_width(side_t'(WIDTH_ALL_ONES));
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b0, 1'b1);
    // two by two block of ones
    write_width(side_t'(2));
    repeat (3) send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);
    // width dropped mid-row, the next row reads older line buffer entries
    write_width(side_t'(4));
    repeat (6) send_pixel(1'b1, 1'b0);
    write_width(side_t'(2));
    send_pixel(1'b1, 1'b0);
    send_pixel(1'b1, 1'b1);

    // random frames under each flow-control mix
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      phase_end = pixels_sent + RANDOM_ITEMS / 4;
      while (pixels_sent < phase_end) send_random_frame();
    end

    // long output hold-off while one-pixel frames keep coming
    sender_idle_pct = 0;
    stall_pct = 0;
    write_width(side_t'(1));
    stall_hold <= HOLD_CYCLES;
    repeat (40) send_pixel($urandom_range(1), 1'b1);
    in_valid <= 1'b0;

    // drain
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d pixels, %0d frames checked, %0d row width writes",
             pixels_sent, tracker.frames_seen, width_writes);
    $display("summary: widths zero to saturated, mid-row width drops, long result hold-off");
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
